// ===== rtl/yuyv2rgb_pkg.sv =====
// Package for the YUYV 4:2:2 to 24-bit BGR converter.
// Holds field widths, color coefficients, shared item types and arithmetic helpers.
// Depends on nothing; every other file in rtl/ uses it.
`timescale 1ns / 1ps

package yuyv2rgb_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned FrameWidthW    = 13;
  localparam logic [FrameWidthW-1:0] FrameWidthReset = 13'd640;
  localparam int unsigned MaxRowWidthDef = 4096;

  // Words held between the front end and the color datapath.
  localparam int unsigned QueueDepth = 2;

  // Chroma offset and fixed-point coefficients; the coefficients are scaled by 1/256.
  localparam logic [ByteW-1:0] ChromaOffset = 8'd128;
  localparam logic [ByteW-1:0] ByteMax      = 8'd255;
  localparam logic [ByteW-1:0] CoefRedV     = 8'd103;
  localparam logic [ByteW-1:0] CoefGreenU   = 8'd88;
  localparam logic [ByteW-1:0] CoefGreenV   = 8'd183;
  localparam logic [ByteW-1:0] CoefBlueU    = 8'd198;

  typedef struct packed {
    logic second_valid;
    logic row_end;
  } row_flags_t;

  typedef struct packed {
    logic [ByteW-1:0] luma_first;
    logic [ByteW-1:0] chroma_blue;
    logic [ByteW-1:0] luma_second;
    logic [ByteW-1:0] chroma_red;
    row_flags_t       flags;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Removes the 128 offset from a chroma byte.
  function automatic logic signed [ByteW:0] chroma_signed(input logic [ByteW-1:0] c);
    return $signed({1'b0, c}) - $signed({1'b0, ChromaOffset});
  endfunction

  // floor(k * d / 256); the arithmetic shift rounds toward minus infinity.
  function automatic logic signed [ByteW+1:0] scaled_floor(input logic [ByteW-1:0]   k,
                                                          input logic signed [ByteW:0] d);
    logic signed [2*ByteW+1:0] p;
    logic signed [2*ByteW+1:0] s;
    p = $signed({1'b0, k}) * d;
    s = p >>> ByteW;
    return s[ByteW+1:0];
  endfunction

  // Saturates a signed sum to the byte range.
  function automatic logic [ByteW-1:0] clamp_byte(input logic signed [ByteW+2:0] x);
    logic [ByteW-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > $signed({3'b000, ByteMax})) begin
      r = ByteMax;
    end else begin
      r = x[ByteW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/yuyv_to_rgb24_converter_core.sv =====
// Top level of the YUYV 4:2:2 to 24-bit BGR converter.
// Instantiates yuyv2rgb_front, yuyv2rgb_queue and yuyv2rgb_back; uses yuyv2rgb_pkg.
`timescale 1ns / 1ps

// The converter takes one packed YUYV macropixel (Y0, U, Y1, V) per word and
// returns one word holding both pixels as blue, green and red bytes, computed
// with 1/256 fixed-point coefficients and saturated to 0..255. It sustains
// one word per clock while the output is not stalled: the front end tags
// each word with its row flags in the cycle it is accepted, a two-entry
// queue carries it on, and the color datapath is two pipeline stages (chroma
// products, then luma add and clamp) ending in a registered output. A word
// passes through the queue, stage one and the output register. The front
// keeps a column counter against frame_width (clamped to MaxRowWidth) and
// sets row_end on the last macropixel of each row; on an odd width that
// macropixel also has second_valid low, while its second pixel's colors are
// still given in full. A width of zero behaves as a width of one.
// frame_width resets to 640 and is written through the configuration channel,
// which is always ready; write it only while no words are in flight.
module yuyv_to_rgb24_converter_core #(
  parameter int unsigned MaxRowWidth = yuyv2rgb_pkg::MaxRowWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [yuyv2rgb_pkg::FrameWidthW-1:0] cfg_data_i,
  // Input macropixel channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]       luma_first_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]       chroma_blue_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]       luma_second_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]       chroma_red_i,
  // Output pixel-pair channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       blue_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       green_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       red_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       blue_second_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       green_second_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]       red_second_o,
  output logic                                 second_valid_o,
  output logic                                 row_end_o
);

  logic [yuyv2rgb_pkg::FrameWidthW-1:0] frame_width_q, frame_width_d;

  logic                    push;
  logic                    pop;
  yuyv2rgb_pkg::q_item_t   push_item;
  yuyv2rgb_pkg::q_item_t   pop_item;
  yuyv2rgb_pkg::q_status_t q_status;

  // The width register has no side effects, so writes are never held off.
  assign cfg_ready_o   = 1'b1;
  assign frame_width_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : frame_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= yuyv2rgb_pkg::FrameWidthReset;
    end else begin
      frame_width_q <= frame_width_d;
    end
  end

  // The input side stalls only when the queue is full, which depends on
  // registered state alone.
  assign in_stall_o = q_status.full;

  yuyv2rgb_front #(
    .MaxRowWidth (MaxRowWidth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .frame_width_i (frame_width_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  yuyv2rgb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  yuyv2rgb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blue_first_o   (blue_first_o),
    .green_first_o  (green_first_o),
    .red_first_o    (red_first_o),
    .blue_second_o  (blue_second_o),
    .green_second_o (green_second_o),
    .red_second_o   (red_second_o),
    .second_valid_o (second_valid_o),
    .row_end_o      (row_end_o)
  );

  // A second pixel outside the row can only occur on the row's last word.
  a_outside_implies_row_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !second_valid_o) |-> row_end_o
  ) else $error("second pixel flagged outside the row on a word that does not end it");

  // A word pushed into an empty queue cannot leave it in the same cycle.
  a_push_into_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push && q_status.empty) |=> !q_status.empty
  ) else $error("word pushed into an empty queue was lost");

  // The queue only fills up while the output holds a word that is waiting.
  a_full_means_backed_up: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> out_valid_o
  ) else $error("queue full while the output register is empty");

endmodule

// ===== rtl/yuyv2rgb_front.sv =====
// Front end of the converter: accepts macropixels and tags them with row flags.
// Keeps the column counter; depends on yuyv2rgb_pkg.
`timescale 1ns / 1ps

module yuyv2rgb_front #(
  parameter int unsigned MaxRowWidth = yuyv2rgb_pkg::MaxRowWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]        luma_first_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]        chroma_blue_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]        luma_second_i,
  input  logic [yuyv2rgb_pkg::ByteW-1:0]        chroma_red_i,
  input  logic [yuyv2rgb_pkg::FrameWidthW-1:0]  frame_width_i,
  input  yuyv2rgb_pkg::q_status_t               q_status_i,
  output logic                                  push_o,
  output yuyv2rgb_pkg::q_item_t                 push_item_o
);

  localparam int unsigned ColW = (MaxRowWidth > 1) ? $clog2(MaxRowWidth) : 1;
  localparam int unsigned CmpW =
    ((ColW > yuyv2rgb_pkg::FrameWidthW) ? ColW : yuyv2rgb_pkg::FrameWidthW) + 2;

  logic [ColW-1:0] col_q, col_d;
  logic [CmpW-1:0] width_eff;
  logic [CmpW-1:0] width_ext;
  logic [CmpW-1:0] pos_ext;
  logic            second_ok;
  logic            last;

  always_comb begin
    width_ext = CmpW'(frame_width_i);
    width_eff = (width_ext > CmpW'(MaxRowWidth)) ? CmpW'(MaxRowWidth) : width_ext;
    pos_ext   = CmpW'(col_q);
    second_ok = (pos_ext + CmpW'(1)) < width_eff;
    last      = (pos_ext + CmpW'(2)) >= width_eff;
  end

  assign push_o = in_valid_i && !q_status_i.full;

  always_comb begin
    push_item_o.luma_first         = luma_first_i;
    push_item_o.chroma_blue        = chroma_blue_i;
    push_item_o.luma_second        = luma_second_i;
    push_item_o.chroma_red         = chroma_red_i;
    push_item_o.flags.second_valid = second_ok;
    push_item_o.flags.row_end      = last;
  end

  always_comb begin
    col_d = col_q;
    if (push_o) begin
      col_d = last ? '0 : col_q + ColW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/yuyv2rgb_queue.sv =====
// Short first-in first-out queue between the front end and the color datapath.
// Stores tagged macropixels in flip-flops; depends on yuyv2rgb_pkg.
`timescale 1ns / 1ps

module yuyv2rgb_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  yuyv2rgb_pkg::q_item_t   push_item_i,
  input  logic                    pop_i,
  output yuyv2rgb_pkg::q_item_t   pop_item_o,
  output yuyv2rgb_pkg::q_status_t status_o
);

  localparam int unsigned Depth = yuyv2rgb_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  yuyv2rgb_pkg::q_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/yuyv2rgb_back.sv =====
// Color datapath: two pipeline stages turning a tagged macropixel into two BGR pixels.
// Chroma products in the first stage, luma add and clamp in the second; uses yuyv2rgb_pkg.
`timescale 1ns / 1ps

module yuyv2rgb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  yuyv2rgb_pkg::q_status_t           q_status_i,
  input  yuyv2rgb_pkg::q_item_t             q_item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    blue_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    green_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    red_first_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    blue_second_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    green_second_o,
  output logic [yuyv2rgb_pkg::ByteW-1:0]    red_second_o,
  output logic                              second_valid_o,
  output logic                              row_end_o
);

  localparam int unsigned BW = yuyv2rgb_pkg::ByteW;

  // Stage one registers: luma bytes, flags and the three chroma terms.
  logic                         s1_valid_q, s1_valid_d;
  logic [BW-1:0]                s1_luma0_q, s1_luma1_q;
  yuyv2rgb_pkg::row_flags_t     s1_flags_q;
  logic signed [BW+1:0]         s1_red_q, s1_green_q, s1_blue_q;

  logic signed [BW:0]           u_s, v_s;
  logic signed [BW+1:0]         red_term, green_term, blue_term;

  // Output registers.
  logic                         out_valid_q, out_valid_d;
  logic [BW-1:0]                b0_q, g0_q, r0_q, b1_q, g1_q, r1_q;
  yuyv2rgb_pkg::row_flags_t     out_flags_q;

  logic                         out_load;
  logic                         s1_load;
  logic signed [BW+2:0]         y0_s, y1_s;
  logic signed [BW+2:0]         red_s, green_s, blue_s;

  assign out_load = !out_valid_q || !out_stall_i;
  assign s1_load  = !s1_valid_q || out_load;
  assign pop_o    = s1_load && !q_status_i.empty;

  always_comb begin
    u_s        = yuyv2rgb_pkg::chroma_signed(q_item_i.chroma_blue);
    v_s        = yuyv2rgb_pkg::chroma_signed(q_item_i.chroma_red);
    red_term   = $signed({v_s[BW], v_s})
               + yuyv2rgb_pkg::scaled_floor(yuyv2rgb_pkg::CoefRedV, v_s);
    green_term = yuyv2rgb_pkg::scaled_floor(yuyv2rgb_pkg::CoefGreenU, u_s)
               + yuyv2rgb_pkg::scaled_floor(yuyv2rgb_pkg::CoefGreenV, v_s);
    blue_term  = $signed({u_s[BW], u_s})
               + yuyv2rgb_pkg::scaled_floor(yuyv2rgb_pkg::CoefBlueU, u_s);
  end

  always_comb begin
    y0_s    = $signed({3'b000, s1_luma0_q});
    y1_s    = $signed({3'b000, s1_luma1_q});
    red_s   = $signed({s1_red_q[BW+1], s1_red_q});
    green_s = $signed({s1_green_q[BW+1], s1_green_q});
    blue_s  = $signed({s1_blue_q[BW+1], s1_blue_q});
  end

  always_comb begin
    s1_valid_d  = s1_load ? !q_status_i.empty : s1_valid_q;
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_luma0_q <= q_item_i.luma_first;
      s1_luma1_q <= q_item_i.luma_second;
      s1_flags_q <= q_item_i.flags;
      s1_red_q   <= red_term;
      s1_green_q <= green_term;
      s1_blue_q  <= blue_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      b0_q        <= yuyv2rgb_pkg::clamp_byte(y0_s + blue_s);
      g0_q        <= yuyv2rgb_pkg::clamp_byte(y0_s - green_s);
      r0_q        <= yuyv2rgb_pkg::clamp_byte(y0_s + red_s);
      b1_q        <= yuyv2rgb_pkg::clamp_byte(y1_s + blue_s);
      g1_q        <= yuyv2rgb_pkg::clamp_byte(y1_s - green_s);
      r1_q        <= yuyv2rgb_pkg::clamp_byte(y1_s + red_s);
      out_flags_q <= s1_flags_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_first_o   = b0_q;
  assign green_first_o  = g0_q;
  assign red_first_o    = r0_q;
  assign blue_second_o  = b1_q;
  assign green_second_o = g1_q;
  assign red_second_o   = r1_q;
  assign second_valid_o = out_flags_q.second_valid;
  assign row_end_o      = out_flags_q.row_end;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for yuyv_to_rgb24_converter_core.
// Drives macropixel words and frame widths, predicts each BGR pixel pair and its row flags.
// Depends on rtl/yuyv2rgb_pkg.sv and the converter RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ByteW          = yuyv2rgb_pkg::ByteW;
  localparam int unsigned FrameWidthW    = yuyv2rgb_pkg::FrameWidthW;
  localparam int unsigned MaxRowWidthDef = yuyv2rgb_pkg::MaxRowWidthDef;
  localparam logic [FrameWidthW-1:0] FrameWidthReset = yuyv2rgb_pkg::FrameWidthReset;
  localparam logic [ByteW-1:0] ChromaOffset = yuyv2rgb_pkg::ChromaOffset;
  localparam logic [ByteW-1:0] CoefRedV     = yuyv2rgb_pkg::CoefRedV;
  localparam logic [ByteW-1:0] CoefGreenU   = yuyv2rgb_pkg::CoefGreenU;
  localparam logic [ByteW-1:0] CoefGreenV   = yuyv2rgb_pkg::CoefGreenV;
  localparam logic [ByteW-1:0] CoefBlueU    = yuyv2rgb_pkg::CoefBlueU;

  typedef struct packed {
    logic [ByteW-1:0] blue_first;
    logic [ByteW-1:0] green_first;
    logic [ByteW-1:0] red_first;
    logic [ByteW-1:0] blue_second;
    logic [ByteW-1:0] green_second;
    logic [ByteW-1:0] red_second;
    logic             second_valid;
    logic             row_end;
  } pixel_pair_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [FrameWidthW-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [ByteW-1:0]       luma_first_i;
  logic [ByteW-1:0]       chroma_blue_i;
  logic [ByteW-1:0]       luma_second_i;
  logic [ByteW-1:0]       chroma_red_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [ByteW-1:0]       blue_first_o;
  logic [ByteW-1:0]       green_first_o;
  logic [ByteW-1:0]       red_first_o;
  logic [ByteW-1:0]       blue_second_o;
  logic [ByteW-1:0]       green_second_o;
  logic [ByteW-1:0]       red_second_o;
  logic                   second_valid_o;
  logic                   row_end_o;

  // Predicted converter state.
  logic [FrameWidthW-1:0] model_width = FrameWidthReset;
  int unsigned            model_column = 0;
  pixel_pair_t            pending_pairs[$];

  int  mismatch_count = 0;
  int  results_seen = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  hold_request = 1'b0;

  yuyv_to_rgb24_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blue_first_o  (blue_first_o),
    .green_first_o (green_first_o),
    .red_first_o   (red_first_o),
    .blue_second_o (blue_second_o),
    .green_second_o(green_second_o),
    .red_second_o  (red_second_o),
    .second_valid_o(second_valid_o),
    .row_end_o     (row_end_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [ByteW-1:0] saturate_byte(int x);
    if (x < 0) begin
      return '0;
    end
    if (x > 255) begin
      return 8'd255;
    end
    return x[ByteW-1:0];
  endfunction

  // floor(k * d / 256); the shift on a signed int rounds toward minus infinity.
  function automatic int floor_div256(int k, int d);
    return (k * d) >>> 8;
  endfunction

  // Returns {blue, green, red} for one pixel.
  function automatic logic [3*ByteW-1:0] pixel_bgr(int luma, int cb, int cr);
    int red, green, blue;
    red   = luma + cr + floor_div256(int'(CoefRedV), cr);
    green = luma - floor_div256(int'(CoefGreenU), cb) - floor_div256(int'(CoefGreenV), cr);
    blue  = luma + cb + floor_div256(int'(CoefBlueU), cb);
    return {saturate_byte(blue), saturate_byte(green), saturate_byte(red)};
  endfunction

  // Works out the pixel pair for one accepted word and advances the column.
  task automatic predict_pair(input logic [ByteW-1:0] y0, u, y1, v);
    pixel_pair_t pair;
    int          cb, cr;
    int unsigned row_width;
    cb = int'(u) - int'(ChromaOffset);
    cr = int'(v) - int'(ChromaOffset);
    {pair.blue_first, pair.green_first, pair.red_first} = pixel_bgr(int'(y0), cb, cr);
    {pair.blue_second, pair.green_second, pair.red_second} = pixel_bgr(int'(y1), cb, cr);
    row_width = (model_width > MaxRowWidthDef) ? MaxRowWidthDef : model_width;
    pair.second_valid = (model_column + 1 < row_width);
    pair.row_end = (model_column + 2 >= row_width);
    model_column = pair.row_end ? 0 : model_column + 2;
    pending_pairs.push_back(pair);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  task automatic check_field(input string what, input logic [ByteW-1:0] got,
                             input logic [ByteW-1:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Favors the byte extremes and the chroma midpoint now and then.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return ChromaOffset;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // Offers one word after a random gap and holds it until accepted. Valid is
  // only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_macropixel(input logic [ByteW-1:0] y0, u, y1, v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    chroma_blue_i <= u;
    luma_second_i <= y1;
    chroma_red_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pair(y0, u, y1, v);
  endtask

  task automatic send_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end
  endtask

  // Stops offering words until every expected pair has come back.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame_width(input logic [FrameWidthW-1:0] width);
    wait_for_idle();
    cfg_data_i  <= width;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_width = width;
  endtask

  // Byte extremes, neutral chroma and fractional products, at the reset width.
  task automatic test_color_extremes();
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_macropixel(8'd0, 8'd128, 8'd255, 8'd128);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128);
    send_macropixel(8'd16, 8'd128, 8'd235, 8'd128);
    send_macropixel(8'd255, 8'd0, 8'd255, 8'd0);
    send_macropixel(8'd0, 8'd255, 8'd0, 8'd255);
    send_macropixel(8'd128, 8'd1, 8'd128, 8'd254);
    send_macropixel(8'd127, 8'd127, 8'd129, 8'd129);
    send_macropixel(8'd77, 8'd200, 8'd90, 8'd60);
  endtask

  // Runs past the end of the first row at the reset width of 640 pixels.
  task automatic test_reset_width_row();
    send_random(312);
  endtask

  // Width of one, width of zero (same as one), small even and odd widths,
  // and widths at and just above the row limit.
  task automatic test_narrow_and_limit_widths();
    write_frame_width(13'd1);
    send_random(4);
    write_frame_width(13'd0);
    send_random(4);
    write_frame_width(13'd2);
    send_random(4);
    write_frame_width(13'd3);
    send_random(6);
    write_frame_width(13'd4096);
    send_random(3);
    write_frame_width(13'd4097);
    send_random(3);
  endtask

  // Narrowing the row while the column already lies past the new end.
  task automatic test_width_change_mid_row();
    write_frame_width(13'd40);
    send_random(7);
    write_frame_width(13'd10);
    send_random(3);
    write_frame_width(13'd40);
    send_random(5);
    write_frame_width(13'd11);
    send_random(4);
  endtask

  // The sink holds off for a long stretch while words keep coming, so the
  // block fills and stalls its input; then the source pauses until drained.
  task automatic test_backpressure();
    write_frame_width(13'd6);
    hold_request = 1'b1;
    tx_calm = 1'b1;
    send_random(40);
    tx_calm = 1'b0;
    wait_for_idle();
    send_random(12);
  endtask

  // The widest register value clamps to the row limit; words at full rate.
  task automatic test_widest_row();
    write_frame_width(13'h1FFF);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_random(40);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Phases of random widths and traffic; the column carries across phases.
  task automatic test_random_traffic();
    int                     sent;
    int                     phase_len;
    logic [FrameWidthW-1:0] width;
    sent = 0;
    while (sent < 140) begin
      case ($urandom_range(0, 9))
        0: width = FrameWidthW'($urandom);
        1: width = FrameWidthW'($urandom_range(0, 1));
        default: width = FrameWidthW'($urandom_range(2, 48));
      endcase
      write_frame_width(width);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 60);
      send_random(phase_len);
      sent += phase_len;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin : main_sequence
    int n;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    luma_first_i  <= '0;
    chroma_blue_i <= '0;
    luma_second_i <= '0;
    chroma_red_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_color_extremes();
    test_reset_width_row();
    test_narrow_and_limit_widths();
    test_width_change_mid_row();
    test_backpressure();
    test_widest_row();
    test_random_traffic();

    in_valid_i <= 1'b0;
    for (n = 0; n < 5000 && pending_pairs.size() != 0; n++) @(posedge clk_i);
    if (pending_pairs.size() != 0) begin
      report_mismatch("words never returned", 0, pending_pairs.size());
    end
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result sink: a random stall before each word, plus one long hold-off.
  initial begin : result_sink
    int wait_cycles;
    int held;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < 200; held++) @(posedge clk_i);
      end
      wait_cycles = rx_calm ? 0 : $urandom_range(0, 14);
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    pixel_pair_t got;
    pixel_pair_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      got = {blue_first_o, green_first_o, red_first_o, blue_second_o, green_second_o,
             red_second_o, second_valid_o, row_end_o};
      if (pending_pairs.size() == 0) begin
        report_mismatch("word with nothing pending", 0, 0);
      end else begin
        want = pending_pairs.pop_front();
        check_field("blue_first", got.blue_first, want.blue_first);
        check_field("green_first", got.green_first, want.green_first);
        check_field("red_first", got.red_first, want.red_first);
        check_field("blue_second", got.blue_second, want.blue_second);
        check_field("green_second", got.green_second, want.green_second);
        check_field("red_second", got.red_second, want.red_second);
        check_field("second_valid", {7'd0, got.second_valid}, {7'd0, want.second_valid});
        check_field("row_end", {7'd0, got.row_end}, {7'd0, want.row_end});
      end
      results_seen++;
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
